### hw/rtl/bce_pkg.sv
// Shared types, register codes and the discharge table for the battery charge estimator.
// No dependencies.
package bce_pkg;

  localparam int PointCount = 21;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 15;
  localparam int NumW       = 19;
  localparam int DenW       = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [13:0] ChargeFull = 14'd10000;
  localparam logic [13:0] ChargeEmpty = 14'd0;
  localparam logic [9:0]  SegCharge  = 10'd500;

  localparam logic [14:0] ThresholdReset  = 15'd1500;
  localparam logic [13:0] HysteresisReset = 14'd200;

  localparam logic [CfgIndexW-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_HYSTERESIS = 2'd1;

  localparam logic [14:0] PointMv [PointCount] = '{
    15'd12600, 15'd12450, 15'd12330, 15'd12240, 15'd12060, 15'd11940, 15'd11850,
    15'd11730, 15'd11610, 15'd11490, 15'd11370, 15'd11250, 15'd11130, 15'd11010,
    15'd10890, 15'd10770, 15'd10560, 15'd10350, 15'd10050, 15'd9600, 15'd9000
  };

  localparam logic [13:0] PointCharge [PointCount] = '{
    14'd10000, 14'd9500, 14'd9000, 14'd8500, 14'd8000, 14'd7500, 14'd7000,
    14'd6500, 14'd6000, 14'd5500, 14'd5000, 14'd4500, 14'd4000, 14'd3500,
    14'd3000, 14'd2500, 14'd2000, 14'd1500, 14'd1000, 14'd500, 14'd0
  };

  typedef struct packed {
    logic [14:0]        voltage_mv;
    logic signed [15:0] current_ma;
  } sample_t;

  typedef struct packed {
    logic [13:0] charge_x100;
    logic        recomputed;
  } result_t;

  typedef struct packed {
    logic            update;
    logic            interp;
    logic [13:0]     base;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } job_t;

endpackage

### hw/rtl/bce_front.sv
// Front end: configuration registers, busy hysteresis and table segment classification.
// Depends on bce_pkg.
module bce_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bce_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [bce_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  bce_pkg::sample_t               sample,
  input  logic                           queue_full,
  output logic                           push,
  output bce_pkg::job_t                  job
);

  localparam int DenW_L = bce_pkg::DenW;

  logic [14:0] threshold;
  logic [13:0] hysteresis;
  logic        busy;
  logic        computed;
  logic        busy_next;

  logic signed [16:0] upper;
  logic signed [16:0] lower;
  logic signed [16:0] ma;
  logic [4:0]         seg;
  logic [14:0]        hi_v;
  logic [14:0]        lo_v;
  logic [DenW_L-1:0]  dv;

  assign cfg_ready    = !rst;
  assign sample_ready = !rst && !queue_full;
  assign push         = sample_valid && sample_ready;

  assign upper = $signed({2'b00, threshold}) + $signed({3'b000, hysteresis});
  assign lower = $signed({2'b00, threshold}) - $signed({3'b000, hysteresis});
  assign ma    = 17'(sample.current_ma);

  always_comb begin
    busy_next = busy;
    if (!busy && (ma > upper)) begin
      busy_next = 1'b1;
    end else if (busy && (ma < lower)) begin
      busy_next = 1'b0;
    end
  end

  always_comb begin
    seg = '0;
    for (int k = bce_pkg::PointCount - 2; k >= 0; k--) begin
      if (sample.voltage_mv >= bce_pkg::PointMv[k+1]) begin
        seg = 5'(k);
      end
    end
  end

  assign hi_v = bce_pkg::PointMv[seg];
  assign lo_v = bce_pkg::PointMv[5'(seg + 5'd1)];
  assign dv   = DenW_L'(sample.voltage_mv - lo_v);

  always_comb begin
    job.update = !computed || !busy_next;
    job.interp = 1'b0;
    job.base   = bce_pkg::PointCharge[5'(seg + 5'd1)];
    job.num    = bce_pkg::NumW'({9'd0, dv}) * bce_pkg::NumW'(bce_pkg::SegCharge);
    job.den    = DenW_L'(hi_v - lo_v);
    if (sample.voltage_mv >= bce_pkg::PointMv[0]) begin
      job.base = bce_pkg::ChargeFull;
    end else if (sample.voltage_mv <= bce_pkg::PointMv[bce_pkg::PointCount-1]) begin
      job.base = bce_pkg::ChargeEmpty;
    end else begin
      job.interp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= bce_pkg::ThresholdReset;
      hysteresis <= bce_pkg::HysteresisReset;
      busy       <= 1'b0;
      computed   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bce_pkg::REG_THRESHOLD:  threshold  <= cfg_data[14:0];
          bce_pkg::REG_HYSTERESIS: hysteresis <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (push) begin
        busy     <= busy_next;
        computed <= computed || job.update;
      end
    end
  end

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(busy) && $stable(computed))
    else $error("busy state changed without an item");

  a_first_update: assert property (@(posedge clk) disable iff (rst)
    push && !computed |-> job.update)
    else $error("first item after reset not recomputed");

  a_interp_range: assert property (@(posedge clk) disable iff (rst)
    push && job.interp |-> (job.num < job.den * bce_pkg::NumW'(bce_pkg::SegCharge)))
    else $error("segment offset outside its span");

endmodule

### hw/rtl/bce_queue.sv
// Short queue of classified jobs between the front and back ends.
// Depends on bce_pkg.
module bce_queue #(
  parameter int Depth = bce_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bce_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output bce_pkg::job_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bce_pkg::job_t   slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CntW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("pop from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CntW'($past(count) + 1'b1))
    else $error("queue count did not advance");

endmodule

### hw/rtl/bce_back.sv
// Back end: serial restoring divider for the interpolation, cached estimate and result register.
// Depends on bce_pkg.
module bce_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  bce_pkg::job_t    job,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_ready,
  output bce_pkg::result_t result
);

  localparam int NumW = bce_pkg::NumW;
  localparam int DenW = bce_pkg::DenW;
  localparam int CntW = $clog2(NumW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t          state;
  logic [NumW-1:0] work;
  logic [DenW-1:0] rem;
  logic [DenW-1:0] den;
  logic [13:0]     base;
  logic [CntW-1:0] count;
  logic [13:0]     cached;
  logic [DenW:0]   rem_shift;
  logic            fits;
  logic            slot_free;
  logic [13:0]     interp_charge;

  assign slot_free     = !result_valid || result_ready;
  assign pop           = (state == ST_IDLE) && job_valid && slot_free;
  assign rem_shift     = {rem, work[NumW-1]};
  assign fits          = rem_shift >= {1'b0, den};
  assign interp_charge = 14'(base + 14'(work));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      cached       <= '0;
      count        <= '0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (!job.update) begin
              result_valid       <= 1'b1;
              result.charge_x100 <= cached;
              result.recomputed  <= 1'b0;
            end else if (!job.interp) begin
              cached             <= job.base;
              result_valid       <= 1'b1;
              result.charge_x100 <= job.base;
              result.recomputed  <= 1'b1;
            end else begin
              work  <= job.num;
              den   <= job.den;
              base  <= job.base;
              rem   <= '0;
              count <= CntW'(NumW - 1);
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          rem   <= fits ? DenW'(rem_shift - {1'b0, den}) : rem_shift[DenW-1:0];
          work  <= {work[NumW-2:0], fits};
          count <= CntW'(count - 1'b1);
          if (count == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            cached             <= interp_charge;
            result_valid       <= 1'b1;
            result.charge_x100 <= interp_charge;
            result.recomputed  <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_charge_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.charge_x100 <= bce_pkg::ChargeFull)
    else $error("charge above full scale");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> work < NumW'(bce_pkg::SegCharge))
    else $error("interpolation step exceeds segment charge");

  a_cached_match: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.recomputed |-> result.charge_x100 == cached)
    else $error("cached result differs from cached estimate");

endmodule

### hw/rtl/battery_charge_estimator.sv
// Top level of the battery state-of-charge estimator.
// Depends on bce_pkg, bce_front, bce_queue and bce_back.
//
// Takes one voltage/current sample per item and returns one charge estimate in hundredths
// of a percent. The front end updates the busy flag with hysteresis and picks the table
// segment in the accept cycle, then queues the job. A sample that returns the cached value
// or a clamped end point goes from the queue straight into the back end's result register;
// an interpolated one first runs the 19-step serial restoring divider in the back end,
// which handles one job at a time. Samples keep being accepted while the queue has room.
module battery_charge_estimator #(
  parameter int QueueDepth = bce_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bce_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [bce_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  bce_pkg::sample_t              sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output bce_pkg::result_t              result
);

  logic          push;
  logic          pop;
  logic          queue_full;
  logic          queue_not_empty;
  bce_pkg::job_t push_job;
  bce_pkg::job_t head_job;

  bce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .queue_full   (queue_full),
    .push         (push),
    .job          (push_job)
  );

  bce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .head      (head_job)
  );

  bce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (queue_not_empty),
    .job          (head_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### tb/sv/tb_battery_charge_estimator.sv
// Self-checking testbench for battery_charge_estimator: sample and config drivers,
// a result monitor and an in-line charge predictor with its own discharge table.
// Depends on bce_pkg for payload types, register codes and reset values.
module tb_battery_charge_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  import bce_pkg::*;

  localparam logic [CfgIndexW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_SPARE_HI = 2'd3;
  localparam int KneeCount = 21;
  localparam int KneeMv [KneeCount] = '{
    12600, 12450, 12330, 12240, 12060, 11940, 11850, 11730, 11610, 11490,
    11370, 11250, 11130, 11010, 10890, 10770, 10560, 10350, 10050, 9600, 9000
  };
  localparam int KneeCharge [KneeCount] = '{
    10000, 9500, 9000, 8500, 8000, 7500, 7000, 6500, 6000, 5500,
    5000, 4500, 4000, 3500, 3000, 2500, 2000, 1500, 1000, 500, 0
  };

  typedef struct packed {
    logic                 is_cfg;
    logic [CfgIndexW-1:0] reg_index;
    logic [CfgDataW-1:0]  reg_value;
    sample_t              smp;
  } stim_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;

  stim_t   stim_q[$];
  result_t charge_expected_q[$];

  logic [14:0] thr_cfg = ThresholdReset;
  logic [13:0] hys_cfg = HysteresisReset;
  logic        busy_m;
  logic        have_m;
  logic [13:0] cached_m;

  int samples_sent = 0;
  int results_seen = 0;
  int pace = 0;
  int stall = 0;
  int errors = 0;
  logic burst_in = 1'b0;
  logic burst_out = 1'b0;

  battery_charge_estimator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [13:0] charge_at_mv(logic [14:0] mv);
    int v;
    int k;
    v = mv;
    if (v >= KneeMv[0]) return 14'd10000;
    if (v <= KneeMv[KneeCount-1]) return 14'd0;
    for (k = 0; k < KneeCount - 1; k++) begin
      if (v <= KneeMv[k] && v >= KneeMv[k+1]) begin
        return 14'(KneeCharge[k+1] + ((KneeCharge[k] - KneeCharge[k+1]) * (v - KneeMv[k+1]))
                   / (KneeMv[k] - KneeMv[k+1]));
      end
    end
    return 14'd0;
  endfunction

  function automatic result_t estimate_charge(sample_t s);
    int      ma;
    int      upper;
    int      lower;
    logic    refresh;
    result_t r;
    ma = s.current_ma;
    upper = int'(thr_cfg) + int'(hys_cfg);
    lower = int'(thr_cfg) - int'(hys_cfg);
    if (!busy_m && ma > upper) busy_m = 1'b1;
    else if (busy_m && ma < lower) busy_m = 1'b0;
    refresh = !have_m || !busy_m;
    if (refresh) begin
      cached_m = charge_at_mv(s.voltage_mv);
      have_m = 1'b1;
    end
    r.charge_x100 = cached_m;
    r.recomputed = refresh;
    return r;
  endfunction

  function automatic void push_sample(int mv, int ma);
    stim_t t;
    t = '0;
    t.smp.voltage_mv = 15'(mv);
    t.smp.current_ma = 16'(ma);
    stim_q.push_back(t);
  endfunction

  function automatic void push_write(logic [CfgIndexW-1:0] idx, int value);
    stim_t t;
    t = '0;
    t.is_cfg = 1'b1;
    t.reg_index = idx;
    t.reg_value = CfgDataW'(value);
    stim_q.push_back(t);
  endfunction

  function automatic int pick_mv();
    int r;
    int k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, KneeCount - 1);
    if (r < 7) return $urandom_range(8900, 12700);
    if (r == 7) return KneeMv[k] + $urandom_range(0, 2) - 1;
    if (r == 8) return $urandom_range(0, 32767);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 32767;
      2: return 12600;
      default: return 9000;
    endcase
  endfunction

  function automatic int pick_ma(int thr, int hys);
    int r;
    int edge_ma;
    int ma;
    r = $urandom_range(0, 9);
    edge_ma = $urandom_range(0, 1) ? thr + hys : thr - hys;
    if (r < 2) ma = edge_ma + $urandom_range(0, 4) - 2;
    else if (r < 5) ma = edge_ma + $urandom_range(0, 600) - 300;
    else if (r < 8) ma = $urandom_range(0, 65535) - 32768;
    else begin
      case ($urandom_range(0, 3))
        0: ma = -32768;
        1: ma = 32767;
        2: ma = 0;
        default: ma = -1;
      endcase
    end
    if (ma > 32767) ma = 32767;
    if (ma < -32768) ma = -32768;
    return ma;
  endfunction

  always @(posedge clk) begin : drive
    logic  sv_n;
    logic  cv_n;
    int    sent_n;
    stim_t nxt;
    if (rst) begin
      sample_valid <= 1'b0;
      cfg_valid <= 1'b0;
      pace <= 0;
      samples_sent <= 0;
      thr_cfg <= ThresholdReset;
      hys_cfg <= HysteresisReset;
    end else begin
      sv_n = sample_valid;
      cv_n = cfg_valid;
      sent_n = samples_sent;
      if (sample_valid && sample_ready) begin
        sv_n = 1'b0;
        sent_n++;
      end
      if (cfg_valid && cfg_ready) begin
        cv_n = 1'b0;
        case (cfg_index)
          REG_THRESHOLD:  thr_cfg <= cfg_data;
          REG_HYSTERESIS: hys_cfg <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (!sv_n && !cv_n && stim_q.size() != 0) begin
        if (pace != 0) begin
          pace <= pace - 1;
        end else begin
          nxt = stim_q[0];
          if (!nxt.is_cfg) begin
            sample <= nxt.smp;
            sv_n = 1'b1;
            void'(stim_q.pop_front());
            pace <= burst_in ? 0 : $urandom_range(0, 10);
          end else if (sent_n == results_seen) begin
            cfg_index <= nxt.reg_index;
            cfg_data <= nxt.reg_value;
            cv_n = 1'b1;
            void'(stim_q.pop_front());
            pace <= burst_in ? 0 : $urandom_range(0, 10);
          end
        end
      end
      sample_valid <= sv_n;
      cfg_valid <= cv_n;
      samples_sent <= sent_n;
      if ($urandom_range(0, 63) == 0) burst_in <= !burst_in;
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      results_seen <= 0;
      stall = 0;
      busy_m = 1'b0;
      have_m = 1'b0;
      cached_m = '0;
      charge_expected_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        results_seen <= results_seen + 1;
        if (charge_expected_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, got charge_x100=%0d recomputed=%0b",
                   $time, result.charge_x100, result.recomputed);
          errors++;
        end else begin
          want = charge_expected_q.pop_front();
          if (result.charge_x100 !== want.charge_x100) begin
            $display("%0t: charge_x100 mismatch: expected %0d, got %0d",
                     $time, want.charge_x100, result.charge_x100);
            errors++;
          end
          if (result.recomputed !== want.recomputed) begin
            $display("%0t: recomputed mismatch: expected %0b, got %0b",
                     $time, want.recomputed, result.recomputed);
            errors++;
          end
        end
        stall = burst_out ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 47) == 0) burst_out <= !burst_out;
      end
      if (sample_valid && sample_ready) charge_expected_q.push_back(estimate_charge(sample));
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int k;
    int p;
    int thr;
    int hys;
    int knees [6];
    knees = '{12450, 12240, 11010, 10560, 10050, 9600};

    // reset config: threshold 1500, band 1300..1700
    push_sample(11000, 5000);
    push_sample(12000, 5000);
    push_sample(9000, 1400);
    push_sample(9000, 1299);
    push_sample(12600, 1700);
    push_sample(12601, 1701);
    push_sample(20000, 1300);
    push_sample(20000, -32768);
    push_sample(0, 32767);
    push_sample(0, -1);
    push_sample(32767, 0);
    foreach (knees[i]) push_sample(knees[i], 0);
    push_sample(12599, 0);
    push_sample(9001, 0);
    push_sample(10051, 0);
    push_sample(11795, 0);

    // band reaching below zero, hysteresis written with a stray top bit
    push_write(REG_THRESHOLD, 0);
    push_write(REG_HYSTERESIS, 32'h7FFF);
    push_write(REG_SPARE_LO, 32'h1234);
    push_write(REG_SPARE_HI, 32'h7FFF);
    push_sample(11000, 16384);
    push_sample(11000, -16383);
    push_sample(11000, -16384);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin thr = 0; hys = 0; end
        1: begin thr = 32767; hys = 0; end
        2: begin thr = 0; hys = 16383; end
        3: begin thr = 32767; hys = 16383; end
        4: begin thr = $urandom_range(0, 32767); hys = $urandom_range(0, 16383); end
        default: begin thr = $urandom_range(0, 6000); hys = $urandom_range(0, 3000); end
      endcase
      push_write(REG_THRESHOLD, thr);
      push_write(REG_HYSTERESIS, hys | ($urandom_range(0, 1) << 14));
      if ($urandom_range(0, 1)) begin
        push_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom_range(0, 32767));
      end
      for (k = 0; k < 60; k++) push_sample(pick_mv(), pick_ma(thr, hys));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (stim_q.size() != 0 || sample_valid || cfg_valid || charge_expected_q.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
    if (charge_expected_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, charge_expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
